// ----- design/brt_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// brt_pkg
// Shared types and constants of the breakpoint range table.
// -----------------------------------------------------------------------------
package brt_pkg;

   localparam int MAX_BREAKPOINTS = 16;
   localparam int ADDR_W = 20;
   localparam int END_W  = ADDR_W + 1;
   localparam int IDX_W  = (MAX_BREAKPOINTS > 1) ? $clog2(MAX_BREAKPOINTS) : 1;
   localparam int CNT_W  = $clog2(MAX_BREAKPOINTS + 1);

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_CHECK = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DUP  = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [1:0]        operation;
      logic [ADDR_W-1:0] address;
      logic [ADDR_W-1:0] range_start;
      logic [END_W-1:0]  range_end;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic              hit;
      logic [ADDR_W-1:0] hit_address;
      logic [CNT_W-1:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [ADDR_W-1:0] data;
   } mem_wr_type;

endpackage

// ----- design/brt_entry_mem.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// brt_entry_mem
// Breakpoint entry store: one write port, one registered read port.
// -----------------------------------------------------------------------------
module brt_entry_mem (
   input  logic                       clock,
   input  brt_pkg::mem_wr_type        wr,
   input  logic                       rd_en,
   input  logic [brt_pkg::IDX_W-1:0]  rd_addr,
   output logic [brt_pkg::ADDR_W-1:0] rd_data
);
   import brt_pkg::*;

   logic [ADDR_W-1:0] entry_ff [MAX_BREAKPOINTS];
   logic [ADDR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         entry_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/brt_range_cmp.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// brt_range_cmp
// Shared compare unit: tests one address against a half-open range.
// -----------------------------------------------------------------------------
module brt_range_cmp (
   input  logic [brt_pkg::ADDR_W-1:0] value,
   input  logic [brt_pkg::ADDR_W-1:0] lo,
   input  logic [brt_pkg::END_W-1:0]  hi,
   output logic                       in_range
);
   import brt_pkg::*;

   assign in_range = (value >= lo) && ({1'b0, value} < hi);

endmodule

// ----- design/breakpoint_range_table.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// breakpoint_range_table
// Breakpoint address table with add, clear and range check operations.
// -----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; each word yields exactly
// one result word, shown on rsp_data for a single cycle with rsp_valid high.
// The receiver cannot stall, so sample rsp_data whenever rsp_valid is set.
// Clear and unused operation codes answer in the cycle after acceptance. Add and
// check scan the stored entries in add order through one shared range
// comparator fed by a registered-read entry memory, one entry per cycle; the
// scan stops early when an entry falls inside the range, and busy stays high
// for the whole scan.
// -----------------------------------------------------------------------------
module breakpoint_range_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  brt_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_valid,
   output brt_pkg::rsp_type rsp_data
);
   import brt_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   // sequencer state and registered outputs
   state_type         state_ff,     state_in;
   logic [1:0]        op_ff,        op_in;
   logic [ADDR_W-1:0] addr_ff,      addr_in;
   logic [ADDR_W-1:0] lo_ff,        lo_in;
   logic [END_W-1:0]  hi_ff,        hi_in;
   logic [CNT_W-1:0]  count_ff,     count_in;
   logic [CNT_W-1:0]  rd_idx_ff,    rd_idx_in;
   logic              pend_ff,      pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff,       rsp_in;

   // datapath links
   mem_wr_type        mem_wr;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_data;
   logic              in_range;
   logic              scan_done;
   logic              scan_hit;

   brt_entry_mem u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   brt_range_cmp u_cmp (
      .value    (rd_data),
      .lo       (lo_ff),
      .hi       (hi_ff),
      .in_range (in_range)
   );

   // issue a read while entries remain; compare the word read last cycle
   assign rd_en     = (state_ff == S_SCAN) && (rd_idx_ff < count_ff);
   assign scan_hit  = pend_ff && in_range;
   assign scan_done = scan_hit || (!pend_ff && !rd_en);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      pend_in      = pend_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_wr.en    = 1'b0;
      mem_wr.addr  = count_ff[IDX_W-1:0];
      mem_wr.data  = addr_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in     = req_data.operation;
               addr_in   = req_data.address;
               rd_idx_in = '0;
               pend_in   = 1'b0;
               case (req_data.operation)
                  OP_ADD: begin
                     // an add is a check of the single-address range
                     lo_in    = req_data.address;
                     hi_in    = {1'b0, req_data.address} + END_W'(1);
                     state_in = S_SCAN;
                  end
                  OP_CHECK: begin
                     lo_in    = req_data.range_start;
                     hi_in    = req_data.range_end;
                     state_in = S_SCAN;
                  end
                  OP_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{status: ST_OK, hit: 1'b0,
                                      hit_address: '0, entry_count: '0};
                  end
                  default: begin
                     // unused code: answer with nothing changed
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{status: ST_OK, hit: 1'b0,
                                      hit_address: '0, entry_count: count_ff};
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (rd_en) begin
               rd_idx_in = rd_idx_ff + CNT_W'(1);
            end
            pend_in = rd_en;
            if (scan_done) begin
               state_in     = S_IDLE;
               pend_in      = 1'b0;
               rsp_valid_in = 1'b1;
               if (op_ff == OP_ADD) begin
                  rsp_in.hit         = 1'b0;
                  rsp_in.hit_address = '0;
                  if (scan_hit) begin
                     rsp_in.status = ST_DUP;
                  end else if (count_ff >= CNT_W'(MAX_BREAKPOINTS)) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     // append at the tail to keep add order
                     rsp_in.status = ST_OK;
                     mem_wr.en     = 1'b1;
                     count_in      = count_ff + CNT_W'(1);
                  end
                  rsp_in.entry_count = count_in;
               end else begin
                  rsp_in.status      = ST_OK;
                  rsp_in.hit         = scan_hit;
                  rsp_in.hit_address = scan_hit ? rd_data : '0;
                  rsp_in.entry_count = count_ff;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // payload: no reset needed
      op_ff   <= op_in;
      addr_ff <= addr_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- tb/breakpoint_range_table_checker.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// breakpoint_range_table_checker
// Watches both channels of the breakpoint range table and keeps its own copy
// of the table. Each accepted word is predicted and queued. Each result word
// is compared field by field against the oldest prediction.
// -----------------------------------------------------------------------------
module breakpoint_range_table_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  brt_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  brt_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count,
   output int               hit_count,
   output int               full_count
);
   import brt_pkg::*;

   logic [ADDR_W-1:0] bp_table [MAX_BREAKPOINTS];
   int unsigned       bp_count;
   rsp_type           expected_q [$];

   // Apply one word to the table copy and return the result it must produce.
   function automatic rsp_type table_apply(input req_type w);
      rsp_type r;
      bit      seen;
      r    = '0;
      seen = 1'b0;
      case (w.operation)
         OP_ADD: begin
            for (int i = 0; i < bp_count; i++)
               if (bp_table[i] == w.address) seen = 1'b1;
            if (seen) begin
               r.status = ST_DUP;
            end else if (bp_count >= MAX_BREAKPOINTS) begin
               r.status = ST_FULL;
            end else begin
               bp_table[bp_count] = w.address;
               bp_count++;
            end
         end
         OP_CLEAR: begin
            bp_count = 0;
         end
         OP_CHECK: begin
            // earliest-added entry inside [range_start, range_end) wins
            for (int i = 0; i < bp_count; i++) begin
               if (!r.hit && w.range_start <= bp_table[i] &&
                   {1'b0, bp_table[i]} < w.range_end) begin
                  r.hit         = 1'b1;
                  r.hit_address = bp_table[i];
               end
            end
         end
         default: ;
      endcase
      r.entry_count = CNT_W'(bp_count);
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         bp_count = 0;
         expected_q.delete();
         fail_count = 0;
         hit_count  = 0;
         full_count = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display({"%0t: result with nothing expected: ",
                            "status=%0d hit=%0b addr=%05h count=%0d"},
                           $realtime, rsp_data.status, rsp_data.hit,
                           rsp_data.hit_address, rsp_data.entry_count);
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.status !== want.status || rsp_data.hit !== want.hit ||
                   rsp_data.hit_address !== want.hit_address ||
                   rsp_data.entry_count !== want.entry_count) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: mismatch: expected status=%0d hit=%0b ",
                               "addr=%05h count=%0d, got status=%0d hit=%0b ",
                               "addr=%05h count=%0d"},
                              $realtime, want.status, want.hit, want.hit_address,
                              want.entry_count, rsp_data.status, rsp_data.hit,
                              rsp_data.hit_address, rsp_data.entry_count);
               end
            end
         end
         if (start && !busy) begin
            want = table_apply(req_data);
            if (want.hit) hit_count++;
            if (want.status == ST_FULL) full_count++;
            expected_q.push_back(want);
         end
      end
      pending_count = expected_q.size();
   end

endmodule

// ----- tb/breakpoint_range_table_tb.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// breakpoint_range_table_tb
// Drives add, clear, check and unused operation words into the breakpoint
// range table: a directed pass over the edge cases, then random sequences
// built around a small pool of hot addresses so that duplicates, range hits,
// several entries inside one range and a full table all come up often.
// A separate checker predicts and compares; this module gives the verdict.
// -----------------------------------------------------------------------------
module breakpoint_range_table_tb;
   import brt_pkg::*;

   // code the block must ignore
   localparam logic [1:0]       OP_UNUSED = 2'd3;
   // exclusive end just past the top of the address space
   localparam logic [END_W-1:0] END_LIMIT = {1'b1, {ADDR_W{1'b0}}};
   localparam int               WORD_TARGET  = 800;
   localparam int               SETTLE_CYCLES = 40;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   logic    rsp_valid;
   req_type req_data;
   rsp_type rsp_data;

   int fail_count;
   int pending_count;
   int hit_count;
   int full_count;
   int add_sent;
   int clear_sent;
   int check_sent;
   int unused_sent;
   bit steady;

   // addresses that random words cluster around
   logic [ADDR_W-1:0] hot_pool [8];

   breakpoint_range_table dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   breakpoint_range_table_checker table_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .hit_count     (hit_count),
      .full_count    (full_count)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic req_type make_word(input logic [1:0]        op,
                                         input logic [ADDR_W-1:0] addr,
                                         input logic [ADDR_W-1:0] lo,
                                         input logic [END_W-1:0]  hi);
      req_type w;
      w.operation   = op;
      w.address     = addr;
      w.range_start = lo;
      w.range_end   = hi;
      return w;
   endfunction

   // Build one random word. Fields the operation does not use stay random.
   function automatic req_type random_word();
      req_type           w;
      int                pick;
      int                sel;
      logic [ADDR_W-1:0] base;
      w.address     = ADDR_W'($urandom);
      w.range_start = ADDR_W'($urandom);
      w.range_end   = END_W'($urandom_range(END_LIMIT));
      pick = $urandom_range(99);
      sel  = $urandom_range(99);
      base = hot_pool[$urandom_range(7)];
      if (pick < 50) begin
         w.operation = OP_ADD;
         // hot address (likely duplicate), a neighbor of one, or anything
         if (sel < 40)
            w.address = base;
         else if (sel < 80)
            w.address = base + ADDR_W'($urandom_range(63)) - ADDR_W'(32);
      end else if (pick < 95) begin
         w.operation = OP_CHECK;
         if (sel < 60) begin
            // window around a hot address, often holding several entries
            w.range_start = base - ADDR_W'($urandom_range(40));
            w.range_end   = {1'b0, base} + END_W'($urandom_range(40));
            if (w.range_end > END_LIMIT) w.range_end = END_LIMIT;
         end else if (sel < 75) begin
            // single-address range
            w.range_start = (sel < 70) ? base : w.range_start;
            w.range_end   = {1'b0, w.range_start} + END_W'(1);
         end else if (sel < 85) begin
            w.range_end = END_LIMIT;
         end else if (sel < 92) begin
            // empty or inverted range
            w.range_end = {1'b0, w.range_start};
            if (w.range_start >= 3) w.range_end = w.range_end - END_W'($urandom_range(3));
         end
      end else if (pick < 97) begin
         w.operation = OP_CLEAR;
      end else begin
         w.operation = OP_UNUSED;
      end
      return w;
   endfunction

   // Offer one word; hold start high across back-to-back words.
   task automatic send_word(input req_type w);
      if (!steady && $urandom_range(99) < 30) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      case (w.operation)
         OP_ADD:   add_sent++;
         OP_CLEAR: clear_sent++;
         OP_CHECK: check_sent++;
         default:  unused_sent++;
      endcase
   endtask

   // Drop start and wait until every predicted result has come back.
   task automatic drain_results();
      start <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      @(posedge clock);
   endtask

   initial begin
      req_type w;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      steady   = 1'b0;
      for (int i = 0; i < 8; i++) hot_pool[i] = ADDR_W'($urandom);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, extremes, duplicates, ranges, full table.
      send_word(make_word(OP_CHECK, '0, '0, END_LIMIT));
      send_word(make_word(OP_ADD, '0, '1, '0));
      send_word(make_word(OP_ADD, '1, '0, '1));
      send_word(make_word(OP_ADD, '0, '0, '0));
      send_word(make_word(OP_CHECK, '0, '0, END_W'(1)));
      send_word(make_word(OP_CHECK, '0, '1, END_LIMIT));
      send_word(make_word(OP_CHECK, '0, '1, {1'b0, {ADDR_W{1'b1}}}));
      send_word(make_word(OP_CHECK, '0, 20'h80000, END_W'(16)));
      send_word(make_word(OP_CHECK, '1, '0, END_LIMIT));
      send_word(make_word(OP_UNUSED, '1, '1, END_LIMIT));
      for (int i = 0; i < MAX_BREAKPOINTS - 2; i++)
         send_word(make_word(OP_ADD, (i[0] ? 20'hAAAAA : 20'h55555) ^ ADDR_W'(i),
                             '0, '0));
      send_word(make_word(OP_ADD, 20'h12345, '0, '0));
      send_word(make_word(OP_ADD, '1, '0, '0));
      send_word(make_word(OP_CHECK, '0, 20'h55550, 21'h055560));
      send_word(make_word(OP_CLEAR, '1, '1, '1));
      send_word(make_word(OP_CHECK, '0, '0, END_LIMIT));
      drain_results();

      // Random: a long stretch without gaps, one more full drain midway.
      for (int n = 0; n < WORD_TARGET; n++) begin
         steady = (n >= 300 && n < 450);
         if (n == 500) drain_results();
         w = random_word();
         if (w.operation == OP_CLEAR) hot_pool[$urandom_range(7)] = ADDR_W'($urandom);
         send_word(w);
      end

      drain_results();
      // let any stray result surface before the verdict
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d words: %0d add, %0d check, %0d clear, %0d unused code.",
               add_sent + check_sent + clear_sent + unused_sent,
               add_sent, check_sent, clear_sent, unused_sent);
      $display("Range hits %0d, full-table rejects %0d, failures %0d.",
               hit_count, full_count, fail_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog: several times the slowest legal run.
   initial begin
      #2_000_000;
      $display("Timeout with %0d results outstanding.", pending_count);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
